### design/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared widths, register indexes and constants of the PID loop step unit.
// ----------------------------------------------------------------------------
package pidl_pkg;

  // field and datapath widths
  localparam int ADC_W      = 16;
  localparam int MV_W       = 14;
  localparam int ERR_W      = 15;
  localparam int DERR_W     = 16;
  localparam int SUM_W      = 18;
  localparam int GAIN_W     = 16;
  localparam int IBOUND_W   = 17;
  localparam int DBOUND_W   = 13;
  localparam int DRIVE_W    = 14;
  localparam int CODE_W     = 12;
  localparam int BYTE_W     = 8;
  localparam int HIBYTE_W   = 7;
  localparam int ACC_W      = 36;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;

  // default fraction bits of the Q4.12 gains
  localparam int DEF_GAIN_FRAC_BITS = 12;

  // converter scaling
  localparam int ADC_SCALE    = 5000;
  localparam int ADC_SHIFT    = 15;
  localparam int MV_WRAP      = 5000;
  localparam int MV_SPAN      = 10000;
  localparam int DAC_MID      = 2048;
  localparam int DAC_CHAN_SEL = 64;

  // x*2048/10000 == x*128/625, done as x*ceil(2^30/625) >> 23 (exact for 13-bit x)
  localparam int DAC_RECIP_W     = 21;
  localparam int DAC_RECIP       = 1717987;
  localparam int DAC_RECIP_SHIFT = 23;
  localparam int DAC_Q_W         = 11;

  // register reset values
  localparam int RST_TARGET = 2300;
  localparam int RST_KP     = 10240;
  localparam int RST_KI     = 123;
  localparam int RST_KD     = 10240;
  localparam int RST_IBOUND = 100000;
  localparam int RST_DBOUND = 5000;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET      = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_I      = 3'd2,
    REG_GAIN_D      = 3'd3,
    REG_INT_BOUND   = 3'd4,
    REG_DRIVE_BOUND = 3'd5
  } cfg_reg_t;

endpackage

### design/pidl_dac_scale.sv
// ----------------------------------------------------------------------------
// pidl_dac_scale
// Maps a signed drive in millivolts to the 12-bit offset-binary DAC code,
// trunc(drive*2048/10000) + 2048, using a reciprocal multiply.
// ----------------------------------------------------------------------------
module pidl_dac_scale
  import pidl_pkg::*;
(
  input  logic signed [DRIVE_W-1:0] drive,
  output logic        [CODE_W-1:0]  code
);

  localparam int MAG_W  = DRIVE_W - 1;
  localparam int PROD_W = MAG_W + DAC_RECIP_W;

  logic [MAG_W-1:0]   mag;
  logic [PROD_W-1:0]  prod;
  logic [DAC_Q_W-1:0] quo;

  // magnitude of the drive, at most 8191
  assign mag = drive[DRIVE_W-1] ? MAG_W'(-drive) : MAG_W'(drive);

  // quotient by reciprocal multiply, truncated toward zero
  assign prod = PROD_W'(mag) * PROD_W'(DAC_RECIP);
  assign quo  = prod[DAC_RECIP_SHIFT +: DAC_Q_W];

  // offset around midscale
  assign code = drive[DRIVE_W-1] ? (CODE_W'(DAC_MID) - CODE_W'(quo))
                                 : (CODE_W'(DAC_MID) + CODE_W'(quo));

endmodule

### design/pid_adc_dac_loop_step_unit.sv
// ----------------------------------------------------------------------------
// pid_adc_dac_loop_step_unit
// PID control step from a raw bipolar ADC word to an offset-binary DAC code.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result is stalled and gives one result
// item per input item. The integrator and the previous-error register are
// updated in the second stage, so consecutive samples follow back to back;
// the later stages hold the gain multiplies, the accumulate/shift/clamp and
// the DAC scaling. The whole pipeline advances together and stalls only while
// the result register holds an item that is not taken. Configuration writes
// are meant for idle periods.
module pid_adc_dac_loop_step_unit
  import pidl_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] adc_word
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [13:0] measured_mv, [28:14] loop_error,
                                            // [42:29] drive_mv, [54:43] dac_code,
                                            // [62:55] dac_low_byte, [69:63] dac_high_byte
);

  localparam int MVP_W = ADC_W + 13;
  localparam int SH_W  = ACC_W - GAIN_FRAC_BITS;
  localparam int PP_W  = GAIN_W + 1 + ERR_W;
  localparam int IP_W  = GAIN_W + 1 + SUM_W;
  localparam int DP_W  = GAIN_W + 1 + DERR_W;

  // configuration registers
  logic signed [MV_W-1:0]   target_r;
  logic [GAIN_W-1:0]        kp_r, ki_r, kd_r;
  logic [IBOUND_W-1:0]      ibound_r;
  logic [DBOUND_W-1:0]      dbound_r;

  // loop state
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [ERR_W-1:0]  prev_r;

  // pipeline valids
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, out_vld_r;
  logic en;

  // stage payloads
  logic [ADC_W-1:0]          a_word_r;
  logic signed [MV_W-1:0]    b_mv_r, c_mv_r, d_mv_r, o_mv_r;
  logic signed [ERR_W-1:0]   b_err_r, c_err_r, d_err_r, o_err_r;
  logic signed [SUM_W-1:0]   b_sum_r;
  logic signed [DERR_W-1:0]  b_derr_r;
  logic signed [PP_W-1:0]    c_pp_r;
  logic signed [IP_W-1:0]    c_ip_r;
  logic signed [DP_W-1:0]    c_dp_r;
  logic signed [DRIVE_W-1:0] d_drive_r, o_drive_r;
  logic [CODE_W-1:0]         o_code_r;

  // whole pipeline moves unless the result is stalled
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= MV_W'(RST_TARGET);
      kp_r     <= GAIN_W'(RST_KP);
      ki_r     <= GAIN_W'(RST_KI);
      kd_r     <= GAIN_W'(RST_KD);
      ibound_r <= IBOUND_W'(RST_IBOUND);
      dbound_r <= DBOUND_W'(RST_DBOUND);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TARGET:      target_r <= cfg_wdata[MV_W-1:0];
        REG_GAIN_P:      kp_r     <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:      ki_r     <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:      kd_r     <= cfg_wdata[GAIN_W-1:0];
        REG_INT_BOUND:   ibound_r <= cfg_wdata[IBOUND_W-1:0];
        REG_DRIVE_BOUND: dbound_r <= cfg_wdata[DBOUND_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      d_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r   <= in_tvalid;
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      d_vld_r   <= c_vld_r;
      out_vld_r <= d_vld_r;
    end
  end

  // stage a: capture the raw word
  always_ff @(posedge clk) begin
    if (en) begin
      a_word_r <= in_tdata[ADC_W-1:0];
    end
  end

  // stage b: millivolts, error and clamped integrator
  logic [MVP_W-1:0]          mv_prod;
  logic [MV_W-1:0]           mv_u;
  logic signed [MV_W-1:0]    mv;
  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W:0]     sum_raw, ibound_s;

  assign mv_prod  = MVP_W'(a_word_r) * MVP_W'(ADC_SCALE);
  assign mv_u     = mv_prod[ADC_SHIFT +: MV_W];
  assign mv       = (mv_u > MV_W'(MV_WRAP)) ? $signed(mv_u - MV_W'(MV_SPAN))
                                             : $signed(mv_u);
  assign err      = ERR_W'(target_r) - ERR_W'(mv);
  assign sum_raw  = (SUM_W+1)'(sum_r) + (SUM_W+1)'(err);
  assign ibound_s = $signed({2'b00, ibound_r});

  always_comb begin
    if (sum_raw > ibound_s) begin
      sum_nxt = SUM_W'(ibound_s);
    end else if (sum_raw < -ibound_s) begin
      sum_nxt = SUM_W'(-ibound_s);
    end else begin
      sum_nxt = SUM_W'(sum_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      prev_r <= '0;
    end else if (en && a_vld_r) begin
      sum_r  <= sum_nxt;
      prev_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mv_r   <= mv;
      b_err_r  <= err;
      b_sum_r  <= sum_nxt;
      b_derr_r <= DERR_W'(err) - DERR_W'(prev_r);
    end
  end

  // stage c: gain products
  logic signed [GAIN_W:0] kp_s, ki_s, kd_s;
  assign kp_s = $signed({1'b0, kp_r});
  assign ki_s = $signed({1'b0, ki_r});
  assign kd_s = $signed({1'b0, kd_r});

  always_ff @(posedge clk) begin
    if (en) begin
      c_pp_r  <= PP_W'(kp_s) * PP_W'(b_err_r);
      c_ip_r  <= IP_W'(ki_s) * IP_W'(b_sum_r);
      c_dp_r  <= DP_W'(kd_s) * DP_W'(b_derr_r);
      c_mv_r  <= b_mv_r;
      c_err_r <= b_err_r;
    end
  end

  // stage d: accumulate, shift toward zero, clamp
  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]        acc_mag;
  logic [SH_W-1:0]         acc_sh;
  logic [DBOUND_W-1:0]     lim;
  logic signed [DRIVE_W-1:0] drive;

  assign acc     = ACC_W'(c_pp_r) + ACC_W'(c_ip_r) + ACC_W'(c_dp_r);
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign acc_sh  = acc_mag[ACC_W-1:GAIN_FRAC_BITS];
  assign lim     = (acc_sh > SH_W'(dbound_r)) ? dbound_r : acc_sh[DBOUND_W-1:0];
  assign drive   = acc[ACC_W-1] ? -$signed(DRIVE_W'(lim)) : $signed(DRIVE_W'(lim));

  always_ff @(posedge clk) begin
    if (en) begin
      d_drive_r <= drive;
      d_mv_r    <= c_mv_r;
      d_err_r   <= c_err_r;
    end
  end

  // result register: DAC code
  logic [CODE_W-1:0] code;

  pidl_dac_scale u_dac_scale (
    .drive (d_drive_r),
    .code  (code)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      o_mv_r    <= d_mv_r;
      o_err_r   <= d_err_r;
      o_drive_r <= d_drive_r;
      o_code_r  <= code;
    end
  end

  // result packing
  logic [HIBYTE_W-1:0] hi_byte;
  assign hi_byte = HIBYTE_W'(o_code_r[CODE_W-1:BYTE_W]) + HIBYTE_W'(DAC_CHAN_SEL);

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, hi_byte, o_code_r[BYTE_W-1:0], o_code_r,
                       o_drive_r, o_err_r, o_mv_r};

endmodule

### bench/pid_adc_dac_loop_step_unit_tb.sv
// ----------------------------------------------------------------------------
// pid_adc_dac_loop_step_unit_tb
// Self-checking bench for the PID loop step unit.
// ----------------------------------------------------------------------------
// A queue of raw ADC words feeds a stream driver. Each accepted word runs
// through a cycle-free PID predictor that keeps its own integrator, previous
// error and register copies. The resulting DAC result item is queued, and the
// result monitor compares every delivered item field by field against the
// oldest queued one. Register settings change only while the pipe is empty.
// Sender and receiver stall at random, in three idle mixes.
// ----------------------------------------------------------------------------
module pid_adc_dac_loop_step_unit_tb;
  import pidl_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int REPORT_MAX      = 10;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 206;
  localparam int DRAIN_CYCLES    = 10;
  localparam int PAD_W = OUT_DATA_W - (HIBYTE_W + BYTE_W + CODE_W + DRIVE_W + ERR_W + MV_W);

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  // words around zero, full scale and the wrap point at 5000 mV
  localparam logic [ADC_W-1:0] EDGE_WORDS [20] = '{
    16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'h8006, 16'h8007,
    16'hFFFF, 16'hFFFE, 16'h4000, 16'hC000, 16'h5555, 16'hAAAA, 16'h00FF,
    16'hFF00, 16'h8007, 16'h8007, 16'h8007, 16'h7FFF, 16'h7FFF
  };

  // result item, laid out as out_tdata from the top bit down
  typedef struct packed {
    logic [PAD_W-1:0]    pad;
    logic [HIBYTE_W-1:0] hi_byte;
    logic [BYTE_W-1:0]   lo_byte;
    logic [CODE_W-1:0]   code;
    logic [DRIVE_W-1:0]  drive;
    logic [ERR_W-1:0]    err;
    logic [MV_W-1:0]     mv;
  } dac_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [15:0] adc_word
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [13:0] measured_mv, [28:14] loop_error,
                                          // [42:29] drive_mv, [54:43] dac_code,
                                          // [62:55] dac_low_byte, [69:63] dac_high_byte

  // predictor copy of registers and loop state
  longint target_mv, kp, ki, kd, sum_limit, drive_limit;
  longint err_integral, err_prev;

  logic [ADC_W-1:0] adc_words_pending [$];
  dac_result_t      dac_results_due [$];
  dac_result_t      got, want;
  logic [ADC_W-1:0] run_level = '0;
  logic             item_taken = 1'b0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               fail_count = 0;
  int               cycle_count = 0;

  pid_adc_dac_loop_step_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_mag(longint v, longint b);
    if (v > b) return b;
    if (v < -b) return -b;
    return v;
  endfunction

  // one control step: measurement, error, integrator, PID sum, DAC scaling
  function automatic dac_result_t next_dac_result(logic [ADC_W-1:0] word);
    longint mv, e, acc, mag, drive, code;
    dac_result_t r;
    mv = (longint'(word) * ADC_SCALE) >>> ADC_SHIFT;
    if (mv > MV_WRAP) mv = mv - MV_SPAN;
    e = target_mv - mv;
    err_integral = clamp_mag(err_integral + e, sum_limit);
    acc = kp * e + ki * err_integral + kd * (e - err_prev);
    err_prev = e;
    // shift truncates toward zero
    mag = (acc < 0) ? -acc : acc;
    mag = mag >> DEF_GAIN_FRAC_BITS;
    drive = clamp_mag((acc < 0) ? -mag : mag, drive_limit);
    code = drive * DAC_MID / MV_SPAN + DAC_MID;
    r = '0;
    r.mv      = mv[MV_W-1:0];
    r.err     = e[ERR_W-1:0];
    r.drive   = drive[DRIVE_W-1:0];
    r.code    = code[CODE_W-1:0];
    r.lo_byte = code[BYTE_W-1:0];
    r.hi_byte = HIBYTE_W'(code[CODE_W-1:BYTE_W] + DAC_CHAN_SEL);
    return r;
  endfunction

  // mostly random words, with slow runs that push the integrator to its bound
  function automatic logic [ADC_W-1:0] random_adc_word();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return ADC_W'($urandom);
      5, 6, 7: begin
        if ($urandom_range(15) == 0) run_level = ADC_W'($urandom);
        return run_level + ADC_W'($urandom_range(31));
      end
      8: return EDGE_WORDS[$urandom_range(14)];
      default: return ADC_W'(32760 + $urandom_range(15));
    endcase
  endfunction

  // register write, mirrored into the predictor
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_TARGET:      target_mv   = longint'($signed(data[MV_W-1:0]));
      REG_GAIN_P:      kp          = longint'(data[GAIN_W-1:0]);
      REG_GAIN_I:      ki          = longint'(data[GAIN_W-1:0]);
      REG_GAIN_D:      kd          = longint'(data[GAIN_W-1:0]);
      REG_INT_BOUND:   sum_limit   = longint'(data[IBOUND_W-1:0]);
      REG_DRIVE_BOUND: drive_limit = longint'(data[DBOUND_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_gains_bounds(int tgt, int p, int i, int d, int ib, int db);
    write_reg(REG_TARGET, CFG_DATA_W'(tgt));
    write_reg(REG_GAIN_P, CFG_DATA_W'(p));
    write_reg(REG_GAIN_I, CFG_DATA_W'(i));
    write_reg(REG_GAIN_D, CFG_DATA_W'(d));
    write_reg(REG_INT_BOUND, CFG_DATA_W'(ib));
    write_reg(REG_DRIVE_BOUND, CFG_DATA_W'(db));
  endtask

  // register setting for each random phase
  task automatic program_phase(int phase);
    case (phase)
      1: set_gains_bounds(5000, 65535, 65535, 65535, 131071, 8191);
      2: set_gains_bounds(-5000, 0, 0, 0, 0, 0);
      3: set_gains_bounds(-8192, RST_KP, 65535, 0, 1, RST_DBOUND);
      4: set_gains_bounds(8191, 65535, 0, 65535, 131071, 1);
      6: set_gains_bounds(RST_TARGET, RST_KP, RST_KI, RST_KD, RST_IBOUND, RST_DBOUND);
      default: begin
        write_reg(REG_TARGET, $urandom_range(1) ? CFG_DATA_W'($urandom)
                                                : CFG_DATA_W'(int'($urandom_range(10000)) - 5000));
        write_reg(REG_GAIN_P, CFG_DATA_W'($urandom));
        write_reg(REG_GAIN_I, CFG_DATA_W'($urandom_range(1023)));
        write_reg(REG_GAIN_D, CFG_DATA_W'($urandom));
        write_reg(REG_INT_BOUND, CFG_DATA_W'($urandom));
        write_reg(REG_DRIVE_BOUND, $urandom_range(1) ? CFG_DATA_W'($urandom)
                                                     : CFG_DATA_W'($urandom_range(5000)));
      end
    endcase
    write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
  endtask

  task automatic wait_drain();
    while (adc_words_pending.size() != 0 || dac_results_due.size() != 0) @(negedge clk);
  endtask

  // input driver and result-side stalls, both at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || item_taken) begin
        if (adc_words_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= adc_words_pending[0];
        end else begin
          in_tvalid <= 1'b0;
          in_tdata  <= IN_DATA_W'($urandom);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    item_taken = 1'b0;
  end

  // accepted items feed the predictor, delivered items get checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        dac_results_due.push_back(next_dac_result(in_tdata));
        void'(adc_words_pending.pop_front());
        item_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (dac_results_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) $display("unexpected result item %h", out_tdata);
        end else begin
          want = dac_results_due.pop_front();
          if (got.mv !== want.mv || got.err !== want.err || got.drive !== want.drive ||
              got.code !== want.code || got.lo_byte !== want.lo_byte ||
              got.hi_byte !== want.hi_byte || got.pad !== want.pad) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("mismatch want: mv %0d err %0d drive %0d code %0d lo %0d hi %0d pad %0d",
                       $signed(want.mv), $signed(want.err), $signed(want.drive),
                       want.code, want.lo_byte, want.hi_byte, want.pad);
              $display("         got:  mv %0d err %0d drive %0d code %0d lo %0d hi %0d pad %0d",
                       $signed(got.mv), $signed(got.err), $signed(got.drive),
                       got.code, got.lo_byte, got.hi_byte, got.pad);
            end
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[pid_adc_dac_loop_step_unit] ERROR");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    target_mv    = RST_TARGET;
    kp           = RST_KP;
    ki           = RST_KI;
    kd           = RST_KD;
    sum_limit    = RST_IBOUND;
    drive_limit  = RST_DBOUND;
    err_integral = 0;
    err_prev     = 0;
    send_idle_pct = 24;
    recv_idle_pct = 80;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // edge words under reset settings
    foreach (EDGE_WORDS[k]) adc_words_pending.push_back(EDGE_WORDS[k]);
    wait_drain();

    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 80;
        recv_idle_pct = 24;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_phase(phase);
      repeat (ITEMS_PER_PHASE) adc_words_pending.push_back(random_adc_word());
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && dac_results_due.size() == 0) begin
      $display("[pid_adc_dac_loop_step_unit] OK");
    end else begin
      $display("[pid_adc_dac_loop_step_unit] ERROR");
    end
    $finish;
  end

endmodule
